// File: rtl/pfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes for the page-frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Map geometry
    localparam int DEF_MAX_FRAMES = 32768;
    localparam int FRAME_SHIFT    = 12;

    // Register reset values
    localparam logic [31:0] POOL_BASE_RST   = 32'h0100_0000;
    localparam logic [15:0] POOL_FRAMES_RST = 16'd0;

    // Configuration register indexes
    localparam logic REG_POOL_BASE   = 1'b0;
    localparam logic REG_POOL_FRAMES = 1'b1;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NOMEM     = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // Outcome of searching one map word for a free frame
    typedef struct packed {
        logic        hit;
        logic [4:0]  bit_idx;
        logic [31:0] new_word;
    } pick_t;

endpackage : pfa_pkg
`default_nettype wire

// File: rtl/pfa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : pfa_ram
`default_nettype wire

// File: rtl/pfa_word_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_word_pick
// Find the lowest free frame among the valid bits of one map word.
// ----------------------------------------------------------------------------
module pfa_word_pick (
    input  wire logic [31:0]    word,
    input  wire logic [5:0]     valid_cnt,
    output pfa_pkg::pick_t      pick
);
    import pfa_pkg::*;

    logic [31:0] mask;
    logic [31:0] free_bits;
    logic [31:0] lowest;
    logic [4:0]  idx;

    always_comb begin
        // valid_cnt ranges 1..32; bits at or above it lie outside the pool
        if (valid_cnt[5]) begin
            mask = '1;
        end else begin
            mask = (32'h1 << valid_cnt[4:0]) - 32'h1;
        end
        free_bits = ~word & mask;
        // isolate the lowest set bit
        lowest = free_bits & (~free_bits + 32'h1);
        for (int b = 0; b < 5; b++) begin
            idx[b] = 1'b0;
            for (int j = 0; j < 32; j++) begin
                if (((j >> b) & 1) == 1) begin
                    idx[b] = idx[b] | lowest[j];
                end
            end
        end
        pick.hit      = |free_bits;
        pick.bit_idx  = idx;
        pick.new_word = word | lowest;
    end

endmodule : pfa_word_pick
`default_nettype wire

// File: rtl/page_frame_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit allocator of 4096-byte frames over a one-bit-per-frame used map
// held in a RAM of 32-bit words.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Signals              | Word layout (low bit up)
//  --------+-----+----------------------+-------------------------------------
//  s_      | in  | tvalid/tready/tdata  | tdata: release_address[31:0]
//          |     | tuser                | tuser: kind (0 alloc, 1 free)
//  m_      | out | tvalid/tready/tdata  | tdata: frame_address[31:0],
//          |     | tuser                |        frames_in_use[47:32]
//          |     |                      | tuser: status[1:0]
//  cfg_    | in  | wr_en/index/wdata    | 0 pool_base, 1 pool_frames[15:0]
//
//  An allocate reads map words in order, one per cycle on the single read
//  port of the map RAM, and ends at the word holding the first free frame
//  or at the last pool word. A free reads one map word and clears the bit
//  if set; an address outside the pool skips the read. Reset starts a
//  clearing pass over MAX_FRAMES/32 map words (rounded up; 1024 at the
//  default size) during which no word is accepted; configuration writes
//  are taken throughout. One request is in flight at a time; a finished
//  result waits in the output register while the next request is accepted,
//  and the next result holds in the response state until the register is taken.
//
module page_frame_bitmap_allocator #(
    parameter int MAX_FRAMES = pfa_pkg::DEF_MAX_FRAMES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // release_address[31:0]
    input  wire logic [0:0]  s_tuser,   // kind[0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // frame_address[31:0], frames_in_use[47:32]
    output logic      [1:0]  m_tuser,   // status[1:0]

    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import pfa_pkg::*;

    localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW        = AW + 5;                 // frame index width
    localparam int NW        = $clog2(MAX_FRAMES + 1); // frame count width
    localparam int XW        = (NW > IW) ? NW : IW;
    localparam int FW        = 21;                     // fits 2^20 frames

    // controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FLOOK = 3'd3;
    localparam logic [2:0] S_FRMW  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]    state_reg,       state_next;
    logic [31:0]   base_reg,        base_next;
    logic [15:0]   frames_reg,      frames_next;
    logic [15:0]   used_count_reg,  used_count_next;
    logic [NW-1:0] eff_n_reg,       eff_n_next;
    logic [AW-1:0] clr_reg,         clr_next;
    logic [AW-1:0] rd_w_reg,        rd_w_next;
    logic [AW-1:0] chk_w_reg,       chk_w_next;
    logic          rd_pend_reg,     rd_pend_next;
    logic          issue_done_reg,  issue_done_next;
    logic [31:0]   req_addr_reg,    req_addr_next;
    logic [1:0]    res_status_reg,  res_status_next;
    logic [IW-1:0] res_idx_reg,     res_idx_next;
    logic          m_valid_reg,     m_valid_next;
    logic [31:0]   m_addr_reg,      m_addr_next;
    logic [1:0]    m_status_reg,    m_status_next;
    logic [15:0]   m_count_reg,     m_count_next;

    // map RAM ports
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    // word search
    logic [5:0]    valid_cnt;
    pick_t         pick;

    // misc combinational
    logic [FW-1:0] fit_c;
    logic [FW-1:0] n_wide;
    logic [NW-1:0] n_c;
    logic [XW-1:0] n_m1;
    logic [AW-1:0] last_w;
    logic [XW-1:0] rem;
    logic [32:0]   off;
    logic          in_range;
    logic          accept;
    logic          hit;
    logic          rd_scan;
    logic          sel_bit;

    pfa_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pfa_word_pick u_pick (
        .word      (ram_rd_data),
        .valid_cnt (valid_cnt),
        .pick      (pick)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

    always_comb begin
        // usable frames: clamp to the map and to the top of address space
        fit_c = {1'b0, ~base_reg[31:12]} + FW'(1);
        n_wide = FW'(frames_reg);
        if (n_wide > FW'(MAX_FRAMES)) begin
            n_wide = FW'(MAX_FRAMES);
        end
        if (n_wide > fit_c) begin
            n_wide = fit_c;
        end
        n_c = n_wide[NW-1:0];

        // last map word that holds a pool frame
        n_m1   = XW'(eff_n_reg) - XW'(1);
        last_w = n_m1[IW-1:5];

        // pool bits in the word being checked
        rem = XW'(eff_n_reg) - XW'({chk_w_reg, 5'b0});
        if (rem >= XW'(32)) begin
            valid_cnt = 6'd32;
        end else begin
            valid_cnt = rem[5:0];
        end

        // free range check: offset from base, frame number below pool size
        off      = {1'b0, req_addr_reg} - {1'b0, base_reg};
        in_range = !off[32] && (FW'(off[31:12]) < FW'(eff_n_reg));

        hit     = rd_pend_reg & pick.hit;
        rd_scan = (state_reg == S_SCAN) && !issue_done_reg && !hit;
        sel_bit = ram_rd_data[res_idx_reg[4:0]];
    end

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        frames_next     = frames_reg;
        used_count_next = used_count_reg;
        eff_n_next      = eff_n_reg;
        clr_next        = clr_reg;
        rd_w_next       = rd_w_reg;
        chk_w_next      = chk_w_reg;
        rd_pend_next    = 1'b0;
        issue_done_next = issue_done_reg;
        req_addr_next   = req_addr_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = chk_w_reg;
        ram_wr_data = pick.new_word;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_w_reg;

        // drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // configuration is taken in every state
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_POOL_BASE:   base_next   = cfg_wdata;
                REG_POOL_FRAMES: frames_next = cfg_wdata[15:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                // zero one map word per cycle
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    req_addr_next = s_tdata;
                    eff_n_next    = n_c;
                    if (s_tuser[0] == KIND_FREE) begin
                        state_next = S_FLOOK;
                    end else if (n_c == '0) begin
                        res_status_next = ST_NOMEM;
                        state_next      = S_RESP;
                    end else begin
                        rd_w_next       = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue reads back to back; check each word once its registered read data returns
                if (rd_scan) begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = rd_w_reg;
                    rd_pend_next = 1'b1;
                    chk_w_next   = rd_w_reg;
                    rd_w_next    = rd_w_reg + AW'(1);
                    if (rd_w_reg == last_w) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (hit) begin
                    // mark the frame used and stop the scan
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = chk_w_reg;
                    ram_wr_data     = pick.new_word;
                    used_count_next = used_count_reg + 16'd1;
                    res_status_next = ST_ALLOCATED;
                    res_idx_next    = {chk_w_reg, pick.bit_idx};
                    state_next      = S_RESP;
                end else if (rd_pend_reg && chk_w_reg == last_w) begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_RESP;
                end
            end

            S_FLOOK: begin
                if (in_range) begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = off[12+5 +: AW];
                    res_idx_next = off[12 +: IW];
                    state_next   = S_FRMW;
                end else begin
                    res_status_next = ST_IGNORED;
                    state_next      = S_RESP;
                end
            end

            S_FRMW: begin
                // clear the bit if set, otherwise leave the map alone
                if (sel_bit) begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = res_idx_reg[IW-1:5];
                    ram_wr_data     = ram_rd_data & ~(32'h1 << res_idx_reg[4:0]);
                    used_count_next = used_count_reg - 16'd1;
                    res_status_next = ST_FREED;
                end else begin
                    res_status_next = ST_IGNORED;
                end
                state_next = S_RESP;
            end

            S_RESP: begin
                // hold until the output register is free; this cycle also
                // separates a map write from the next request's first read
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_count_next  = used_count_reg;
                    if (res_status_reg == ST_ALLOCATED) begin
                        m_addr_next = base_reg + (32'(res_idx_reg) << FRAME_SHIFT);
                    end else begin
                        m_addr_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            base_reg       <= POOL_BASE_RST;
            frames_reg     <= POOL_FRAMES_RST;
            used_count_reg <= '0;
            clr_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            frames_reg     <= frames_next;
            used_count_reg <= used_count_next;
            clr_reg        <= clr_next;
            rd_pend_reg    <= rd_pend_next;
            issue_done_reg <= issue_done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        eff_n_reg      <= eff_n_next;
        rd_w_reg       <= rd_w_next;
        chk_w_reg      <= chk_w_next;
        req_addr_reg   <= req_addr_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

endmodule : page_frame_bitmap_allocator
`default_nettype wire
